### rtl/gn3_pkg.sv
// Shared constants and types for the 3D gradient noise evaluator.
// No dependencies; imported by gradient_noise_3d_eval_core.
package gn3_pkg;

    localparam logic [1:0] OP_WR_PERM  = 2'd0;
    localparam logic [1:0] OP_WR_GRAD  = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [3:0] FREQ_LOG2_RESET = 4'd2;

    localparam int GRAD_W  = 16;
    localparam int COORD_W = 32;
    localparam int NOISE_W = 16;

    typedef struct packed {
        logic signed [GRAD_W-1:0] z;
        logic signed [GRAD_W-1:0] y;
        logic signed [GRAD_W-1:0] x;
    } grad_t;

endpackage

### rtl/gradient_noise_3d_eval_core.sv
// Pipelined 3D gradient noise evaluator with replicated table memories.
// Depends on gn3_pkg (opcodes, gradient entry type).

// Takes one item per clock while in_ready is high: permutation writes,
// gradient writes and noise evaluations, in any mix. An evaluation flows
// through an eight-stage pipeline with no feedback, whose
// table reads are served by replicated single-write memories (one two-port
// permutation copy for the x corners, two for the y corners, four two-port
// gradient copies for the eight corners), each copy written at the stage
// where it is read so that writes and evaluations keep their order. Results
// collect in a 16-entry output queue; up to 16 evaluations may be pending,
// and in_ready drops only when that many are in flight or waiting. Table
// entries read before they are written return undefined values.
module gradient_noise_3d_eval_core
    import gn3_pkg::*;
#(
    parameter int TABLE_DEPTH     = 256,
    parameter int COORD_FRAC_BITS = 16
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [3:0]                 cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 operation,
    input  logic [7:0]                 table_index,
    input  logic [7:0]                 perm_value,
    input  logic signed [GRAD_W-1:0]   grad_x,
    input  logic signed [GRAD_W-1:0]   grad_y,
    input  logic signed [GRAD_W-1:0]   grad_z,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [NOISE_W-1:0]  noise_value
);

    localparam int C    = COORD_FRAC_BITS;
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FMAX = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int RW   = C + 1;
    localparam int SW   = C + 2;
    localparam int PW   = GRAD_W + RW;
    localparam int SUMW = PW + 2;
    localparam int DW   = SUMW - C;
    localparam int LW   = DW + 3;
    localparam int PRW  = SW + 1 + LW;
    localparam int FD   = 16;
    localparam int FAW  = $clog2(FD);

    localparam logic [SW-1:0]          THREE_ONE = SW'(3) << C;
    localparam logic signed [SUMW-1:0] DOT_HALF  = SUMW'(1) << (C - 1);
    localparam logic signed [PRW-1:0]  LRP_HALF  = PRW'(1) << (C - 1);

    function automatic logic signed [LW-1:0] lerp(input logic [SW-1:0] s,
                                                  input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b);
        logic signed [LW-1:0]  diff;
        logic signed [PRW-1:0] prod;
        logic signed [PRW-1:0] rnd;
        diff = b - a;
        prod = PRW'($signed({1'b0, s})) * PRW'(diff);
        rnd  = (prod + LRP_HALF) >>> C;
        return a + rnd[LW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [3:0] freq_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            freq_reg <= FREQ_LOG2_RESET;
        else if (cfg_we)
            freq_reg <= cfg_wdata;
    end

    logic [3:0]    freq_eff;
    logic [AW:0]   one_sh;
    logic [AW:0]   mask_wide;
    logic [AW-1:0] mask;
    always_comb
    begin
        freq_eff  = (freq_reg > 4'(FMAX)) ? 4'(FMAX) : freq_reg;
        one_sh    = (AW+1)'(1) << freq_eff;
        mask_wide = one_sh - 1'b1;
        mask      = mask_wide[AW-1:0];
    end

    // ---------------- memories ----------------
    logic [7:0] perm_a_mem  [TABLE_DEPTH];
    logic [7:0] perm_b0_mem [TABLE_DEPTH];
    logic [7:0] perm_b1_mem [TABLE_DEPTH];
    grad_t      grad_mem    [4][TABLE_DEPTH];

    // ---------------- credit and handshake ----------------
    logic [FAW:0] credit_reg;
    logic [FAW:0] credit_next;
    logic         in_xfer;
    logic         out_xfer;
    assign in_ready = (credit_reg < (FAW+1)'(FD));
    assign in_xfer  = in_valid && in_ready;

    // ---------------- stage 1 ----------------
    logic                      s1_v_reg;
    logic [1:0]                s1_op_reg;
    logic [7:0]                s1_idx_reg;
    logic [7:0]                s1_pval_reg;
    grad_t                     s1_grad_reg;
    logic signed [COORD_W-1:0] s1_c_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= operation;
        s1_idx_reg  <= table_index;
        s1_pval_reg <= perm_value;
        s1_grad_reg <= '{z: grad_z, y: grad_y, x: grad_x};
        s1_c_reg[0] <= coord_x;
        s1_c_reg[1] <= coord_y;
        s1_c_reg[2] <= coord_z;
    end

    logic signed [COORD_W-1:0] s1_csh [3];
    logic [AW-1:0]             s1_lat0 [3];
    logic [AW-1:0]             s1_lat1 [3];
    logic [C-1:0]              s1_frac [3];
    logic                      s1_idx_ok;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_csh[i]  = s1_c_reg[i] >>> C;
            s1_lat0[i] = s1_csh[i][AW-1:0] & mask;
            s1_lat1[i] = (s1_lat0[i] + 1'b1) & mask;
            s1_frac[i] = s1_c_reg[i][C-1:0];
        end
        s1_idx_ok = (32'(s1_idx_reg) < 32'(TABLE_DEPTH));
    end

    // ---------------- stage 2 ----------------
    logic          s2_v_reg;
    logic [1:0]    s2_op_reg;
    logic [7:0]    s2_idx_reg;
    logic [7:0]    s2_pval_reg;
    grad_t         s2_grad_reg;
    logic [AW-1:0] s2_by_reg [2];
    logic [AW-1:0] s2_bz_reg [2];
    logic [C-1:0]  s2_frac_reg [3];
    logic [7:0]    s2_p_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg   <= s1_op_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_pval_reg <= s1_pval_reg;
        s2_grad_reg <= s1_grad_reg;
        s2_by_reg[0] <= s1_lat0[1];
        s2_by_reg[1] <= s1_lat1[1];
        s2_bz_reg[0] <= s1_lat0[2];
        s2_bz_reg[1] <= s1_lat1[2];
        for (int i = 0; i < 3; i++)
            s2_frac_reg[i] <= s1_frac[i];
        // x-corner permutation lookups
        s2_p_reg[0] <= perm_a_mem[s1_lat0[0]];
        s2_p_reg[1] <= perm_a_mem[s1_lat1[0]];
        if (s1_v_reg && s1_op_reg == OP_WR_PERM && s1_idx_ok)
            perm_a_mem[AW'(s1_idx_reg)] <= s1_pval_reg;
    end

    logic [AW-1:0] s2_baddr [4];
    logic [2*C-1:0] s2_tt [3];
    logic          s2_idx_ok;
    always_comb
    begin
        for (int j = 0; j < 4; j++)
            s2_baddr[j] = (AW'(s2_p_reg[j % 2]) + s2_by_reg[j / 2]) & mask;
        for (int i = 0; i < 3; i++)
            s2_tt[i] = (2*C)'(s2_frac_reg[i]) * (2*C)'(s2_frac_reg[i]);
        s2_idx_ok = (32'(s2_idx_reg) < 32'(TABLE_DEPTH));
    end

    // ---------------- stage 3 ----------------
    logic          s3_v_reg;
    logic [1:0]    s3_op_reg;
    logic [7:0]    s3_idx_reg;
    grad_t         s3_grad_reg;
    logic [AW-1:0] s3_bz_reg [2];
    logic [C-1:0]  s3_frac_reg [3];
    logic [C-1:0]  s3_q_reg [3];
    logic [7:0]    s3_b_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else
            s3_v_reg <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_op_reg   <= s2_op_reg;
        s3_idx_reg  <= s2_idx_reg;
        s3_grad_reg <= s2_grad_reg;
        s3_bz_reg[0] <= s2_bz_reg[0];
        s3_bz_reg[1] <= s2_bz_reg[1];
        for (int i = 0; i < 3; i++)
        begin
            s3_frac_reg[i] <= s2_frac_reg[i];
            s3_q_reg[i]    <= s2_tt[i][2*C-1:C];
        end
        // y-corner lookups, two per copy
        s3_b_reg[0] <= perm_b0_mem[s2_baddr[0]];
        s3_b_reg[1] <= perm_b0_mem[s2_baddr[1]];
        s3_b_reg[2] <= perm_b1_mem[s2_baddr[2]];
        s3_b_reg[3] <= perm_b1_mem[s2_baddr[3]];
        if (s2_v_reg && s2_op_reg == OP_WR_PERM && s2_idx_ok)
        begin
            perm_b0_mem[AW'(s2_idx_reg)] <= s2_pval_reg;
            perm_b1_mem[AW'(s2_idx_reg)] <= s2_pval_reg;
        end
    end

    logic [AW-1:0]   s3_gaddr [8];
    logic [SW-1:0]   s3_w [3];
    logic [2*C+1:0]  s3_qw [3];
    logic            s3_idx_ok;
    logic            s3_eval;
    always_comb
    begin
        for (int k = 0; k < 8; k++)
            s3_gaddr[k] = (AW'(s3_b_reg[k % 4]) + s3_bz_reg[k / 4]) & mask;
        for (int i = 0; i < 3; i++)
        begin
            s3_w[i]  = THREE_ONE - SW'({s3_frac_reg[i], 1'b0});
            s3_qw[i] = (2*C+2)'(s3_q_reg[i]) * (2*C+2)'(s3_w[i]);
        end
        s3_idx_ok = (32'(s3_idx_reg) < 32'(TABLE_DEPTH));
        s3_eval   = s3_v_reg && (s3_op_reg == OP_EVAL);
    end

    // ---------------- stage 4 ----------------
    logic          s4_ev_reg;
    logic [C-1:0]  s4_frac_reg [3];
    logic [SW-1:0] s4_s_reg [3];
    grad_t         s4_g_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_ev_reg <= 1'b0;
        else
            s4_ev_reg <= s3_eval;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s4_frac_reg[i] <= s3_frac_reg[i];
            s4_s_reg[i]    <= s3_qw[i][2*C+1:C];
        end
        for (int k = 0; k < 8; k++)
            s4_g_reg[k] <= grad_mem[k / 2][s3_gaddr[k]];
        if (s3_v_reg && s3_op_reg == OP_WR_GRAD && s3_idx_ok)
        begin
            for (int n = 0; n < 4; n++)
                grad_mem[n][AW'(s3_idx_reg)] <= s3_grad_reg;
        end
    end

    // corner offsets: t for the low corner, t - 1 for the high corner
    logic signed [RW-1:0] s4_r [8][3];
    logic signed [PW-1:0] s4_prod [8][3];
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            s4_r[k][0] = $signed({((k % 2) == 1), s4_frac_reg[0]});
            s4_r[k][1] = $signed({(((k / 2) % 2) == 1), s4_frac_reg[1]});
            s4_r[k][2] = $signed({((k / 4) == 1), s4_frac_reg[2]});
            s4_prod[k][0] = PW'(s4_g_reg[k].x) * PW'(s4_r[k][0]);
            s4_prod[k][1] = PW'(s4_g_reg[k].y) * PW'(s4_r[k][1]);
            s4_prod[k][2] = PW'(s4_g_reg[k].z) * PW'(s4_r[k][2]);
        end
    end

    // ---------------- stage 5 ----------------
    logic                 s5_ev_reg;
    logic [SW-1:0]        s5_s_reg [3];
    logic signed [PW-1:0] s5_prod_reg [8][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_ev_reg <= 1'b0;
        else
            s5_ev_reg <= s4_ev_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            s5_s_reg[i] <= s4_s_reg[i];
        for (int k = 0; k < 8; k++)
            for (int i = 0; i < 3; i++)
                s5_prod_reg[k][i] <= s4_prod[k][i];
    end

    logic signed [SUMW-1:0] s5_sum [8];
    logic signed [SUMW-1:0] s5_rnd [8];
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            s5_sum[k] = SUMW'(s5_prod_reg[k][0]) + SUMW'(s5_prod_reg[k][1])
                      + SUMW'(s5_prod_reg[k][2]);
            s5_rnd[k] = (s5_sum[k] + DOT_HALF) >>> C;
        end
    end

    // ---------------- stage 6: blend along x ----------------
    logic                 s6_ev_reg;
    logic [SW-1:0]        s6_s_reg [3];
    logic signed [DW-1:0] s6_dot_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_ev_reg <= 1'b0;
        else
            s6_ev_reg <= s5_ev_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            s6_s_reg[i] <= s5_s_reg[i];
        for (int k = 0; k < 8; k++)
            s6_dot_reg[k] <= s5_rnd[k][DW-1:0];
    end

    logic signed [LW-1:0] s6_ex [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            s6_ex[i] = lerp(s6_s_reg[0], LW'(s6_dot_reg[2*i]), LW'(s6_dot_reg[2*i+1]));
    end

    // ---------------- stage 7: blend along y ----------------
    logic                 s7_ev_reg;
    logic [SW-1:0]        s7_sy_reg;
    logic [SW-1:0]        s7_sz_reg;
    logic signed [LW-1:0] s7_ex_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_ev_reg <= 1'b0;
        else
            s7_ev_reg <= s6_ev_reg;
    end

    always_ff @(posedge clk)
    begin
        s7_sy_reg <= s6_s_reg[1];
        s7_sz_reg <= s6_s_reg[2];
        for (int i = 0; i < 4; i++)
            s7_ex_reg[i] <= s6_ex[i];
    end

    logic signed [LW-1:0] s7_ey [2];
    always_comb
    begin
        s7_ey[0] = lerp(s7_sy_reg, s7_ex_reg[0], s7_ex_reg[1]);
        s7_ey[1] = lerp(s7_sy_reg, s7_ex_reg[2], s7_ex_reg[3]);
    end

    // ---------------- stage 8: blend along z, saturate ----------------
    logic                 s8_ev_reg;
    logic [SW-1:0]        s8_sz_reg;
    logic signed [LW-1:0] s8_ey_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_ev_reg <= 1'b0;
        else
            s8_ev_reg <= s7_ev_reg;
    end

    always_ff @(posedge clk)
    begin
        s8_sz_reg    <= s7_sz_reg;
        s8_ey_reg[0] <= s7_ey[0];
        s8_ey_reg[1] <= s7_ey[1];
    end

    logic signed [LW-1:0]      s8_r;
    logic signed [NOISE_W-1:0] s8_sat;
    always_comb
    begin
        s8_r = lerp(s8_sz_reg, s8_ey_reg[0], s8_ey_reg[1]);
        if (s8_r > LW'(32767))
            s8_sat = 16'sh7fff;
        else if (s8_r < -LW'(32768))
            s8_sat = 16'sh8000;
        else
            s8_sat = s8_r[NOISE_W-1:0];
    end

    // ---------------- output queue ----------------
    logic [NOISE_W-1:0] fifo_mem [FD];
    logic [FAW-1:0]     wr_ptr_reg;
    logic [FAW-1:0]     rd_ptr_reg;
    logic [FAW:0]       count_reg;

    assign out_valid   = (count_reg != '0);
    assign out_xfer    = out_valid && out_ready;
    assign noise_value = $signed(fifo_mem[rd_ptr_reg]);

    always_ff @(posedge clk)
    begin
        if (s8_ev_reg)
            fifo_mem[wr_ptr_reg] <= s8_sat;
    end

    always_comb
    begin
        credit_next = credit_reg;
        if (in_xfer && operation == OP_EVAL)
            credit_next = credit_next + 1'b1;
        if (out_xfer)
            credit_next = credit_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (s8_ev_reg)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (out_xfer)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            // push and pop in one cycle leave the count unchanged
            if (s8_ev_reg && !out_xfer)
                count_reg <= count_reg + 1'b1;
            else if (!s8_ev_reg && out_xfer)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### sim/gn3_noise_checker.sv
// Checker for the 3D gradient noise evaluator: watches both channels and the
// config port, predicts noise values and compares them. Depends on gn3_pkg.
`timescale 1ns / 100ps

module gn3_noise_checker
    import gn3_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [3:0]                cfg_wdata,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic [7:0]                table_index,
    input  logic [7:0]                perm_value,
    input  logic signed [GRAD_W-1:0]  grad_x,
    input  logic signed [GRAD_W-1:0]  grad_y,
    input  logic signed [GRAD_W-1:0]  grad_z,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [NOISE_W-1:0] noise_value,
    output int                        pending,
    output int                        fail_count
);

    localparam int FRAC = 16;

    logic [7:0]         perm_mem [256];
    grad_t              grad_mem [256];
    logic [3:0]         freq_log2;
    logic signed [15:0] noise_expected [$];

    function automatic longint rnd16(longint v);
        return (v + 64'sd32768) >>> FRAC;
    endfunction

    function automatic longint fade(longint t);
        longint q;
        q = (t * t) >>> FRAC;
        return (q * (3 * (64'sd1 <<< FRAC) - 2 * t)) >>> FRAC;
    endfunction

    function automatic longint mix(longint s, longint a, longint b);
        return a + rnd16(s * (b - a));
    endfunction

    function automatic longint corner_dot(int idx, longint rx, longint ry, longint rz);
        grad_t g;
        g = grad_mem[idx];
        return rnd16(longint'(g.x) * rx + longint'(g.y) * ry + longint'(g.z) * rz);
    endfunction

    function automatic logic signed [15:0] predict_noise(logic signed [31:0] cx,
                                                         logic signed [31:0] cy,
                                                         logic signed [31:0] cz);
        int     m, x0, y0, z0, x1, y1, z1, p0, p1, b00, b10, b01, b11;
        longint fx, fy, fz, gx, gy, gz, sx, sy, sz, c1, c2, r;
        m  = (1 << ((freq_log2 > 8) ? 8 : freq_log2)) - 1;
        x0 = int'(longint'(cx) >>> FRAC) & m;
        y0 = int'(longint'(cy) >>> FRAC) & m;
        z0 = int'(longint'(cz) >>> FRAC) & m;
        x1 = (x0 + 1) & m;
        y1 = (y0 + 1) & m;
        z1 = (z0 + 1) & m;
        fx = longint'(cx[15:0]);
        fy = longint'(cy[15:0]);
        fz = longint'(cz[15:0]);
        gx = fx - 65536;
        gy = fy - 65536;
        gz = fz - 65536;
        p0  = perm_mem[x0];
        p1  = perm_mem[x1];
        b00 = perm_mem[(p0 + y0) & m];
        b10 = perm_mem[(p1 + y0) & m];
        b01 = perm_mem[(p0 + y1) & m];
        b11 = perm_mem[(p1 + y1) & m];
        sx = fade(fx);
        sy = fade(fy);
        sz = fade(fz);
        c1 = mix(sy, mix(sx, corner_dot((b00 + z0) & m, fx, fy, fz),
                             corner_dot((b10 + z0) & m, gx, fy, fz)),
                     mix(sx, corner_dot((b01 + z0) & m, fx, gy, fz),
                             corner_dot((b11 + z0) & m, gx, gy, fz)));
        c2 = mix(sy, mix(sx, corner_dot((b00 + z1) & m, fx, fy, gz),
                             corner_dot((b10 + z1) & m, gx, fy, gz)),
                     mix(sx, corner_dot((b01 + z1) & m, fx, gy, gz),
                             corner_dot((b11 + z1) & m, gx, gy, gz)));
        r = mix(sz, c1, c2);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    assign pending = noise_expected.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_log2 = FREQ_LOG2_RESET;
            noise_expected.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                freq_log2 = cfg_wdata;
            if (in_valid && in_ready)
            begin
                case (operation)
                    OP_WR_PERM: perm_mem[table_index] = perm_value;
                    OP_WR_GRAD: grad_mem[table_index] = '{z: grad_z, y: grad_y, x: grad_x};
                    OP_EVAL:    noise_expected.push_back(predict_noise(coord_x, coord_y,
                                                                       coord_z));
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (noise_expected.size() == 0)
                begin
                    $error("noise_value: unexpected result %0d", noise_value);
                    fail_count++;
                end
                else
                begin
                    logic signed [15:0] want;
                    want = noise_expected.pop_front();
                    if (want !== noise_value)
                    begin
                        $error("noise_value mismatch: expected %0d, actual %0d",
                               want, noise_value);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

### sim/gradient_noise_3d_eval_core_tb.sv
// Testbench top for gradient_noise_3d_eval_core: drives tables, config and
// noise evaluations; checking lives in gn3_noise_checker. Depends on gn3_pkg.
`timescale 1ns / 100ps

module gradient_noise_3d_eval_core_tb;
    import gn3_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic [3:0]         cfg_wdata = '0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [1:0]         operation = OP_EVAL;
    logic [7:0]         table_index = '0;
    logic [7:0]         perm_value = '0;
    logic signed [15:0] grad_x = '0, grad_y = '0, grad_z = '0;
    logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [15:0] noise_value;
    int                 pending, fail_count;
    bit                 calm = 0;
    bit                 hold_req = 0;

    always #1 clk = ~clk;

    gradient_noise_3d_eval_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .table_index(table_index), .perm_value(perm_value),
        .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_ready(out_ready), .noise_value(noise_value)
    );

    gn3_noise_checker chk (.*);

    // Offer one item and return at the edge where it transfers.
    task automatic offer(logic [1:0] op, logic [7:0] idx, logic [7:0] pv,
                         logic [47:0] g, logic [95:0] c);
        bit ok;
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid    <= 1;
        operation   <= op;
        table_index <= idx;
        perm_value  <= pv;
        {grad_z, grad_y, grad_x}    <= g;
        {coord_z, coord_y, coord_x} <= c;
        do
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end while (!ok);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_freq(logic [3:0] f);
        drain();
        cfg_we    <= 1;
        cfg_wdata <= f;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [15:0] rand_grad();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            2:       return {16'($signed($urandom_range(16)) - 8), 16'($urandom)};
            default: return {16'($urandom_range(300)), 16'($urandom)};
        endcase
    endfunction

    task automatic rand_item();
        int k;
        k = $urandom_range(99);
        if (k < 62)
            offer(OP_EVAL, 8'($urandom), 8'($urandom), 48'($urandom),
                  {rand_coord(), rand_coord(), rand_coord()});
        else if (k < 77)
            offer(OP_WR_PERM, 8'($urandom), 8'($urandom), 48'($urandom), 96'($urandom));
        else if (k < 92)
            offer(OP_WR_GRAD, 8'($urandom), 8'($urandom),
                  {rand_grad(), rand_grad(), rand_grad()}, 96'($urandom));
        else
            offer(OP_RESERVED, 8'($urandom), 8'($urandom), 48'($urandom), 96'($urandom));
    endtask

    // Receiver: random stalls, plus one long hold on request.
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 0;
                for (n = 0; n < 250; n++)
                    @(posedge clk);
                hold_req = 0;
            end
            out_ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [3:0] freqs [7];
        int         n_items;
        freqs = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd5, 4'd3, 4'd7};
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Fill every entry so no evaluation reads an unwritten one.
        calm = 1;
        for (int i = 0; i < 256; i++)
        begin
            offer(OP_WR_PERM, 8'(i), 8'($urandom), '0, '0);
            offer(OP_WR_GRAD, 8'(i), '0, {rand_grad(), rand_grad(), rand_grad()}, '0);
        end
        calm = 0;

        // Directed: coordinate and gradient extremes, ignored op, negatives.
        offer(OP_WR_GRAD, 8'd0, '0, {16'sh7fff, 16'sh8000, 16'sd16384}, '0);
        offer(OP_WR_GRAD, 8'd1, '0, {-16'sd16384, 16'sd16384, -16'sd16384}, '0);
        offer(OP_WR_PERM, 8'd255, 8'd255, '0, '0);
        offer(OP_RESERVED, 8'd5, 8'd7, '1, '1);
        offer(OP_EVAL, '0, '0, '0, {32'h0, 32'h0, 32'h0});
        offer(OP_EVAL, '0, '0, '0, {32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        offer(OP_EVAL, '0, '0, '0, {32'h80000000, 32'h80000000, 32'h80000000});
        offer(OP_EVAL, '0, '0, '0, {32'hffffffff, 32'h0000ffff, 32'hffff0000});
        offer(OP_EVAL, '0, '0, '0, {32'h00008000, 32'hffff8000, 32'h00018000});
        offer(OP_EVAL, '0, '0, '0, {32'hfffe4000, 32'h0003c000, 32'h7fff0001});

        for (int ph = 0; ph < 7; ph++)
        begin
            set_freq(freqs[ph]);
            if (ph == 2)
                calm = 1;
            n_items = (ph == 3) ? 60 : 20;
            for (int i = 0; i < n_items; i++)
            begin
                if (ph == 3 && i == 5)
                    hold_req = 1;
                if (ph == 4 && i == 10)
                    drain();
                rand_item();
            end
            calm = 0;
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
